// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that check themselves.
// No dependencies; each file that uses these includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define QFP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent at one edge implies the consequent at the next edge.
`define QFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QFP_ASSERT_ALWAYS(label, expr, msg)
`define QFP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/qfp_pkg.sv =====
// Types, codes and constants of the field line parser.
// No dependencies; imported by every module of the block.
`default_nettype none
package qfp_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_IDX_CONT  = 3'd1,
    PH_NIDX_CONT = 3'd2,
    PH_LEN_FIRST = 3'd3,
    PH_LEN_CONT  = 3'd4,
    PH_STR_DATA  = 3'd5,
    PH_DRAIN     = 3'd6
  } phase_t;

  // result event codes
  localparam logic [2:0] EV_INDEXED_FIELD = 3'd0;
  localparam logic [2:0] EV_INDEXED_NAME  = 3'd1;
  localparam logic [2:0] EV_NAME_BYTE     = 3'd2;
  localparam logic [2:0] EV_VALUE_BYTE    = 3'd3;
  localparam logic [2:0] EV_FIELD_DONE    = 3'd4;
  localparam logic [2:0] EV_BLOCK_DONE    = 3'd5;
  localparam logic [2:0] EV_ERROR         = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE            = 3'd0;
  localparam logic [2:0] ERR_BAD_INDEX       = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN_PATTERN = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW        = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED       = 3'd4;

  // prefix integer limits
  localparam logic [6:0] PREFIX7_MAX = 7'h7F;
  localparam logic [5:0] PREFIX6_MAX = 6'h3F;
  localparam logic [3:0] CONT_LIMIT  = 4'd8;   // last count with a 7-bit step shift
  localparam logic [3:0] OVF_COUNT   = 4'd9;   // continuation count that overflows
  localparam logic [5:0] SHIFT_CAP   = 6'd56;
  localparam logic [5:0] CONT_STEP   = 6'd7;

  localparam int MAX_EVENTS = 3;

  typedef struct packed {
    logic [2:0] ev;
    logic [6:0] idx;
    logic [7:0] sbyte;
    logic       huff;
    logic [2:0] err;
  } event_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]                  cnt;
    event_t [MAX_EVENTS-1:0]     evs;
  } bundle_t;

  function automatic event_t mk_ev(logic [2:0] ev, logic [6:0] idx, logic [7:0] sb,
                                   logic huff, logic [2:0] err);
    event_t e;
    e.ev    = ev;
    e.idx   = idx;
    e.sbyte = sb;
    e.huff  = huff;
    e.err   = err;
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qfp_in_if.sv =====
// Input channel of the parser: one header block byte per item.
// Depends on nothing.
`default_nettype none
interface qfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_block;

  modport source (output valid, output in_byte, output end_of_block, input ready);
  modport sink   (input valid, input in_byte, input end_of_block, output ready);
endinterface
`default_nettype wire

// ===== rtl/qfp_out_if.sv =====
// Result channel of the parser: one event per item.
// Depends on nothing.
`default_nettype none
interface qfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [6:0] static_index;
  logic [7:0] string_byte;
  logic       huffman_coded;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output event_res, output static_index, output string_byte,
                  output huffman_coded, output error_code, output last, input ready);
  modport sink   (input valid, input event_res, input static_index, input string_byte,
                  input huffman_coded, input error_code, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/qfp_front.sv =====
// Front end: accepts bytes, runs the field line parser and bundles the events of each byte.
// Depends on qfp_pkg and qfp_in_if.
`default_nettype none
module qfp_front
  import qfp_pkg::*;
#(
  parameter int STATIC_ENTRIES = 99
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  qfp_in_if.sink       in_s,
  input  wire logic    q_full,
  output logic         push,
  output bundle_t      push_data
);

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic        huff_r, huff_nxt;
  logic        isval_r, isval_nxt;

  logic [7:0]  b;
  logic        eob;
  logic        fire;

  assign in_s.ready = !q_full;
  assign fire       = in_s.valid && in_s.ready;
  assign b          = in_s.in_byte;
  assign eob        = in_s.end_of_block;

  // byte classification
  logic st_idle, st_cont, st_lenf, st_data;
  logic low7_full, low6_full;
  logic pat_unknown, pat_literal, start_multi;

  assign st_idle   = (phase_r == PH_IDLE);
  assign st_cont   = (phase_r == PH_IDX_CONT) || (phase_r == PH_NIDX_CONT) ||
                     (phase_r == PH_LEN_CONT);
  assign st_lenf   = (phase_r == PH_LEN_FIRST);
  assign st_data   = (phase_r == PH_STR_DATA);
  assign low7_full = (b[6:0] == PREFIX7_MAX);
  assign low6_full = (b[5:0] == PREFIX6_MAX);

  assign pat_unknown = st_idle && !b[7] && !b[6] && !b[5];
  assign pat_literal = st_idle && !b[7] && !b[6] && b[5];
  assign start_multi = (st_idle && b[7] && low7_full) ||
                       (st_idle && !b[7] && b[6] && low6_full) ||
                       (st_lenf && low7_full);

  // continuation byte accumulation
  logic [5:0]  sh;
  logic [63:0] acc_sum;
  logic [3:0]  cnt_inc;
  logic        ovf;

  assign sh      = (cnt_r > CONT_LIMIT) ? SHIFT_CAP : (6'({2'b00, cnt_r}) * CONT_STEP);
  assign acc_sum = acc_r + (64'(b[6:0]) << sh);
  assign cnt_inc = cnt_r + 4'd1;
  assign ovf     = b[7] && (cnt_inc >= OVF_COUNT);

  // index completion
  logic        idx_req, idx_name, idx_bad;
  logic [63:0] idx_val;

  assign idx_req  = (st_idle && b[7] && !low7_full) ||
                    (st_idle && !b[7] && b[6] && !low6_full) ||
                    (((phase_r == PH_IDX_CONT) || (phase_r == PH_NIDX_CONT)) && !b[7]);
  assign idx_name = st_idle ? !b[7] : (phase_r == PH_NIDX_CONT);
  assign idx_val  = st_idle ? (b[7] ? 64'(b[6:0]) : 64'(b[5:0])) : acc_sum;
  assign idx_bad  = (idx_val == 64'd0) || (idx_val >= 64'(STATIC_ENTRIES));

  // string begin and end
  logic        sb_req, sb_empty, sd_done, se_req;
  logic [63:0] sb_len;

  assign sb_req   = (st_lenf && !low7_full) || ((phase_r == PH_LEN_CONT) && !b[7]);
  assign sb_len   = st_lenf ? 64'(b[6:0]) : acc_sum;
  assign sb_empty = (sb_len == 64'd0);
  assign sd_done  = (rem_r[63:1] == 63'd0);
  assign se_req   = (sb_req && sb_empty) || (st_data && sd_done);

  // outcome of this byte
  logic err_now, fld_done;

  assign err_now = pat_unknown ||
                   (st_cont && b[7] && (ovf || eob)) ||
                   (idx_req && (idx_bad || (idx_name && eob))) ||
                   (sb_req && !sb_empty && eob) ||
                   (se_req && !isval_r && eob) ||
                   (start_multi && eob) ||
                   (pat_literal && eob) ||
                   (st_data && !sd_done && eob);
  assign fld_done = (idx_req && !idx_bad && !idx_name) || (se_req && isval_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (err_now) begin
      phase_nxt = eob ? PH_IDLE : PH_DRAIN;
    end else if (fld_done) begin
      phase_nxt = PH_IDLE;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (b[7])      phase_nxt = PH_IDX_CONT;
          else if (b[6]) phase_nxt = low6_full ? PH_NIDX_CONT : PH_LEN_FIRST;
          else           phase_nxt = PH_LEN_FIRST;
        end
        PH_IDX_CONT, PH_NIDX_CONT: begin
          if (!b[7]) phase_nxt = PH_LEN_FIRST;
        end
        PH_LEN_FIRST, PH_LEN_CONT: begin
          if (sb_req) phase_nxt = sb_empty ? PH_LEN_FIRST : PH_STR_DATA;
          else        phase_nxt = PH_LEN_CONT;
        end
        PH_STR_DATA: begin
          if (sd_done) phase_nxt = PH_LEN_FIRST;
        end
        PH_DRAIN: begin
          if (eob) phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // integer and string datapath
  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    huff_nxt  = huff_r;
    isval_nxt = isval_r;
    if (start_multi) begin
      acc_nxt = st_idle ? (b[7] ? 64'(PREFIX7_MAX) : 64'(PREFIX6_MAX)) : 64'(PREFIX7_MAX);
      cnt_nxt = 4'd0;
    end
    if (st_cont) begin
      acc_nxt = acc_sum;
      cnt_nxt = cnt_inc;
    end
    if (st_lenf) huff_nxt = b[7];
    if (sb_req) rem_nxt = sb_len;
    if (st_data) rem_nxt = rem_r - 64'(rem_r != 64'd0);
    if (pat_literal) isval_nxt = 1'b0;
    if (idx_req && !idx_bad && idx_name) isval_nxt = 1'b1;
    if (se_req && !isval_r) isval_nxt = 1'b1;
  end

  // events of this byte, in order
  logic [1:0] n;
  always_comb begin
    push_data = '0;
    n         = 2'd0;
    if (st_data) begin
      push_data.evs[n] = mk_ev(isval_r ? EV_VALUE_BYTE : EV_NAME_BYTE, 7'd0, b, huff_r,
                               ERR_NONE);
      n = n + 2'd1;
    end
    if (pat_unknown) begin
      push_data.evs[n] = mk_ev(EV_ERROR, 7'd0, 8'd0, 1'b0, ERR_UNKNOWN_PATTERN);
      n = n + 2'd1;
    end
    if (st_cont && b[7] && (ovf || eob)) begin
      push_data.evs[n] = mk_ev(EV_ERROR, 7'd0, 8'd0, 1'b0, ovf ? ERR_OVERFLOW : ERR_TRUNCATED);
      n = n + 2'd1;
    end
    if ((start_multi || pat_literal) && eob) begin
      push_data.evs[n] = mk_ev(EV_ERROR, 7'd0, 8'd0, 1'b0, ERR_TRUNCATED);
      n = n + 2'd1;
    end
    if (idx_req) begin
      if (idx_bad) begin
        push_data.evs[n] = mk_ev(EV_ERROR, 7'd0, 8'd0, 1'b0, ERR_BAD_INDEX);
        n = n + 2'd1;
      end else begin
        push_data.evs[n] = mk_ev(idx_name ? EV_INDEXED_NAME : EV_INDEXED_FIELD,
                                 idx_val[6:0], 8'd0, 1'b0, ERR_NONE);
        n = n + 2'd1;
        if (!idx_name) begin
          push_data.evs[n] = mk_ev(EV_FIELD_DONE, 7'd0, 8'd0, 1'b0, ERR_NONE);
          n = n + 2'd1;
          if (eob) begin
            push_data.evs[n] = mk_ev(EV_BLOCK_DONE, 7'd0, 8'd0, 1'b0, ERR_NONE);
            n = n + 2'd1;
          end
        end else if (eob) begin
          push_data.evs[n] = mk_ev(EV_ERROR, 7'd0, 8'd0, 1'b0, ERR_TRUNCATED);
          n = n + 2'd1;
        end
      end
    end
    if (sb_req && !sb_empty && eob) begin
      push_data.evs[n] = mk_ev(EV_ERROR, 7'd0, 8'd0, 1'b0, ERR_TRUNCATED);
      n = n + 2'd1;
    end
    if (se_req) begin
      if (isval_r) begin
        push_data.evs[n] = mk_ev(EV_FIELD_DONE, 7'd0, 8'd0, 1'b0, ERR_NONE);
        n = n + 2'd1;
        if (eob) begin
          push_data.evs[n] = mk_ev(EV_BLOCK_DONE, 7'd0, 8'd0, 1'b0, ERR_NONE);
          n = n + 2'd1;
        end
      end else if (eob) begin
        push_data.evs[n] = mk_ev(EV_ERROR, 7'd0, 8'd0, 1'b0, ERR_TRUNCATED);
        n = n + 2'd1;
      end
    end
    if (st_data && !sd_done && eob) begin
      push_data.evs[n] = mk_ev(EV_ERROR, 7'd0, 8'd0, 1'b0, ERR_TRUNCATED);
      n = n + 2'd1;
    end
    push_data.cnt = n;
  end

  assign push = fire && (n != 2'd0);

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
      rem_r   <= '0;
      huff_r  <= 1'b0;
      isval_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      huff_r  <= huff_nxt;
      isval_r <= isval_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qfp_queue.sv =====
// Short queue of event bundles between the parser and the result stage.
// Depends on qfp_pkg.
`default_nettype none
module qfp_queue
  import qfp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output bundle_t      pop_data,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  bundle_t         slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // bundle storage
  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== rtl/qfp_emit.sv =====
// Result stage: holds one bundle and hands out its events one per item, marking the last.
// Depends on qfp_pkg and qfp_out_if.
`default_nettype none
module qfp_emit
  import qfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_empty,
  input  wire bundle_t q_data,
  output logic         pop,
  qfp_out_if.source    out_m
);

  bundle_t     cur_r;
  logic        have_r;
  logic [1:0]  k_r;
  logic        fire, is_last, finishing;
  event_t      ev;

  assign ev        = cur_r.evs[k_r];
  assign is_last   = (k_r == cur_r.cnt - 2'd1);
  assign fire      = out_m.valid && out_m.ready;
  assign finishing = !have_r || (fire && is_last);
  assign pop       = finishing && !q_empty;

  assign out_m.valid         = have_r;
  assign out_m.event_res     = ev.ev;
  assign out_m.static_index  = ev.idx;
  assign out_m.string_byte   = ev.sbyte;
  assign out_m.huffman_coded = ev.huff;
  assign out_m.error_code    = ev.err;
  assign out_m.last          = is_last;

  // bundle load and event step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      k_r    <= 2'd0;
    end else if (pop) begin
      have_r <= 1'b1;
      k_r    <= 2'd0;
    end else if (fire && is_last) begin
      have_r <= 1'b0;
    end else if (fire) begin
      k_r <= k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_data;
  end

endmodule
`default_nettype wire

// ===== rtl/qpack_field_line_parser.sv =====
// Field line parser for QPACK header blocks that use the static table only. Bytes enter
// one per item with a flag on the last byte of a block; each byte yields zero to three
// events (indexed field, indexed name, name byte, value byte, field done, block done,
// error), the last one of a byte flagged by last. String bytes pass through raw with their
// Huffman flag. The parser takes one byte per cycle while the queue is not full; the result
// port gives one event per cycle while ready is high, and a queue of QUEUE_DEPTH per-byte
// bundles absorbs the bursts of bytes with two or three events before the input stalls.
// With the result stage free, the first event of a byte passes through the queue and the
// result stage register before it is valid. Indexes of zero or of STATIC_ENTRIES and above
// are reported as bad. After an error the rest of the block is dropped without results.
`default_nettype none
`include "assert_macros.svh"
module qpack_field_line_parser
  import qfp_pkg::*;
#(
  parameter int STATIC_ENTRIES = 99,
  parameter int QUEUE_DEPTH    = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qfp_in_if.sink     in_s,
  qfp_out_if.source  out_m
);

  logic    push, q_full, q_empty, pop;
  bundle_t push_data, q_data;

  qfp_front #(
    .STATIC_ENTRIES(STATIC_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_s),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  qfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  qfp_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_data),
    .pop     (pop),
    .out_m   (out_m)
  );

  // checks across the front, queue and result stage
  `QFP_ASSERT_ALWAYS(a_no_push_full, !(push && q_full), "bundle pushed into a full queue")
  `QFP_ASSERT_ALWAYS(a_push_nonempty, !push || (push_data.cnt != 2'd0), "empty bundle pushed")
  `QFP_ASSERT_NEXT(a_bundle_continues, out_m.valid && out_m.ready && !out_m.last, out_m.valid, "bundle cut short")
  `QFP_ASSERT_NEXT(a_queue_drains, !out_m.valid && !q_empty, out_m.valid, "queued bundle not loaded")

endmodule
`default_nettype wire
